// File: rtl/core/ars_pkg.sv
`timescale 1ns / 1ps

package ars_pkg;

  localparam int unsigned MAX_PROCS = 1024;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned STG_W = 5;
  localparam int unsigned BLK_W = 10;

  typedef struct packed {
    logic start;
    logic emit_err;
    logic emit_dbl;
    logic gth_step;
  } ars_cmd_t;

  typedef struct packed {
    logic bad;
    logic dbl_more;
    logic dbl_last;
    logic gth_hit;
    logic gth_last;
    logic out_free;
  } ars_sts_t;

endpackage

// File: rtl/core/ars_ctrl.sv
`timescale 1ns / 1ps

module ars_ctrl
  import ars_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ars_sts_t sts,
  output ars_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DBL  = 2'd1;
  localparam logic [1:0] ST_GTH  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DBL;
        end
      end
      ST_DBL: begin
        if (sts.out_free) begin
          if (sts.bad) begin
            cmd.emit_err = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.emit_dbl = 1'b1;
            if (sts.dbl_last) begin
              state_nxt = ST_IDLE;
            end else if (!sts.dbl_more) begin
              state_nxt = ST_GTH;
            end
          end
        end
      end
      ST_GTH: begin
        if (!sts.gth_hit || sts.out_free) begin
          cmd.gth_step = 1'b1;
          if (sts.gth_hit && sts.gth_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: rtl/core/ars_datapath.sv
`timescale 1ns / 1ps

module ars_datapath
  import ars_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] in_proc_index,
  input  logic [CNT_W-1:0] in_proc_count,
  input  ars_cmd_t         cmd,
  output ars_sts_t         sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [STG_W-1:0] out_stage_number,
  output logic [STG_W-1:0] out_source_stage,
  output logic [STG_W-1:0] out_result_stage,
  output logic [BLK_W-1:0] out_step_size,
  output logic [BLK_W-1:0] out_block_offset,
  output logic [IDX_W-1:0] out_target_proc,
  output logic             out_last,
  output logic             out_error
);

  logic [IDX_W-1:0] index_r, index_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [STG_W-1:0] stage_r, stage_nxt;
  logic [STG_W-1:0] gsrc_r, gsrc_nxt;
  logic [BLK_W-1:0] g_r, g_nxt;
  logic [CNT_W-1:0] covered_r, covered_nxt;
  logic [BLK_W-1:0] remain_r, remain_nxt;

  logic             ov_r, ov_nxt;
  logic [STG_W-1:0] o_stage_r, o_stage_nxt;
  logic [STG_W-1:0] o_src_r, o_src_nxt;
  logic [STG_W-1:0] o_res_r, o_res_nxt;
  logic [BLK_W-1:0] o_step_r, o_step_nxt;
  logic [BLK_W-1:0] o_off_r, o_off_nxt;
  logic [IDX_W-1:0] o_tgt_r, o_tgt_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_err_r, o_err_nxt;

  logic [CNT_W-1:0] sel_off;
  logic [CNT_W:0]   diff;
  logic [CNT_W:0]   wrapped;
  logic [IDX_W-1:0] target;
  logic [CNT_W-1:0] p_dbl;
  logic             gth_load;
  logic             load;

  assign p_dbl = {p_r[CNT_W-2:0], 1'b0};

  assign sts.bad      = (count_r < CNT_W'(2)) || ({1'b0, index_r} >= count_r) ||
                        (count_r > CNT_W'(MAX_PROCS));
  assign sts.dbl_more = ({p_r, 2'b00} <= {2'b00, count_r});
  assign sts.dbl_last = ({p_r, 1'b0} == {1'b0, count_r});
  assign sts.gth_hit  = |(remain_r & g_r);
  assign sts.gth_last = (remain_r == g_r);
  assign sts.out_free = !ov_r || !out_stall;

  assign gth_load = cmd.gth_step && sts.gth_hit;
  assign load     = cmd.emit_err || cmd.emit_dbl || gth_load;

  always_comb begin
    sel_off = cmd.emit_dbl ? p_r : covered_r;
    diff    = {2'b00, index_r} - {1'b0, sel_off};
    wrapped = diff + {1'b0, count_r};
    if ({1'b0, index_r} >= sel_off) begin
      target = diff[IDX_W-1:0];
    end else begin
      target = wrapped[IDX_W-1:0];
    end
  end

  always_comb begin
    index_nxt   = index_r;
    count_nxt   = count_r;
    p_nxt       = p_r;
    stage_nxt   = stage_r;
    gsrc_nxt    = gsrc_r;
    g_nxt       = g_r;
    covered_nxt = covered_r;
    remain_nxt  = remain_r;
    if (cmd.start) begin
      index_nxt = in_proc_index;
      count_nxt = in_proc_count;
      p_nxt     = CNT_W'(1);
      stage_nxt = '0;
    end
    if (cmd.emit_dbl) begin
      p_nxt       = p_dbl;
      stage_nxt   = stage_r + STG_W'(1);
      covered_nxt = p_dbl;
      remain_nxt  = BLK_W'(count_r - p_dbl);
      g_nxt       = p_r[BLK_W-1:0];
      gsrc_nxt    = stage_r;
    end
    if (cmd.gth_step) begin
      g_nxt    = g_r >> 1;
      gsrc_nxt = gsrc_r - STG_W'(1);
      if (sts.gth_hit) begin
        covered_nxt = covered_r + {1'b0, g_r};
        remain_nxt  = remain_r - g_r;
        stage_nxt   = stage_r + STG_W'(1);
      end
    end
  end

  always_comb begin
    o_stage_nxt = o_stage_r;
    o_src_nxt   = o_src_r;
    o_res_nxt   = o_res_r;
    o_step_nxt  = o_step_r;
    o_off_nxt   = o_off_r;
    o_tgt_nxt   = o_tgt_r;
    o_last_nxt  = o_last_r;
    o_err_nxt   = o_err_r;
    ov_nxt      = ov_r && out_stall;
    if (load) begin
      ov_nxt = 1'b1;
    end
    if (cmd.emit_err) begin
      o_stage_nxt = '0;
      o_src_nxt   = '0;
      o_res_nxt   = '0;
      o_step_nxt  = '0;
      o_off_nxt   = '0;
      o_tgt_nxt   = '0;
      o_last_nxt  = 1'b1;
      o_err_nxt   = 1'b1;
    end else if (cmd.emit_dbl) begin
      o_stage_nxt = stage_r;
      o_src_nxt   = stage_r;
      o_res_nxt   = stage_r + STG_W'(1);
      o_step_nxt  = p_r[BLK_W-1:0];
      o_off_nxt   = p_r[BLK_W-1:0];
      o_tgt_nxt   = target;
      o_last_nxt  = sts.dbl_last;
      o_err_nxt   = 1'b0;
    end else if (gth_load) begin
      o_stage_nxt = stage_r;
      o_src_nxt   = gsrc_r;
      o_res_nxt   = stage_r + STG_W'(1);
      o_step_nxt  = g_r;
      o_off_nxt   = covered_r[BLK_W-1:0];
      o_tgt_nxt   = target;
      o_last_nxt  = sts.gth_last;
      o_err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    index_r   <= index_nxt;
    count_r   <= count_nxt;
    p_r       <= p_nxt;
    stage_r   <= stage_nxt;
    gsrc_r    <= gsrc_nxt;
    g_r       <= g_nxt;
    covered_r <= covered_nxt;
    remain_r  <= remain_nxt;
    o_stage_r <= o_stage_nxt;
    o_src_r   <= o_src_nxt;
    o_res_r   <= o_res_nxt;
    o_step_r  <= o_step_nxt;
    o_off_r   <= o_off_nxt;
    o_tgt_r   <= o_tgt_nxt;
    o_last_r  <= o_last_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign out_valid        = ov_r;
  assign out_stage_number = o_stage_r;
  assign out_source_stage = o_src_r;
  assign out_result_stage = o_res_r;
  assign out_step_size    = o_step_r;
  assign out_block_offset = o_off_r;
  assign out_target_proc  = o_tgt_r;
  assign out_last         = o_last_r;
  assign out_error        = o_err_r;

endmodule

// File: rtl/core/allreduce_stage_schedule.sv
// Channel | Direction | Fields
// in_     | input     | proc_index[9:0], proc_count[10:0]
// out_    | output    | stage_number, source_stage, result_stage, step_size,
//         |           | block_offset, target_proc, last, error
//
// One request is loaded, then the sequencer steps once per doubling stage and once
// per bit walked in the gather phase.
// A bad request (count below 2, index not below count, count above 1024)
// gives one error transaction after acceptance.
// The stage sequencer accepts a new request only when the previous one is done.
// Output stalls hold the result register and pause the sequencer whenever it has a transaction to issue.
// Reset is synchronous, active low, and clears the sequencer and out_valid.
`timescale 1ns / 1ps

module allreduce_stage_schedule
  import ars_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] in_proc_index,
  input  logic [CNT_W-1:0] in_proc_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [STG_W-1:0] out_stage_number,
  output logic [STG_W-1:0] out_source_stage,
  output logic [STG_W-1:0] out_result_stage,
  output logic [BLK_W-1:0] out_step_size,
  output logic [BLK_W-1:0] out_block_offset,
  output logic [IDX_W-1:0] out_target_proc,
  output logic             out_last,
  output logic             out_error
);

  ars_cmd_t cmd;
  ars_sts_t sts;

  ars_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ars_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_proc_index    (in_proc_index),
    .in_proc_count    (in_proc_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stage_number (out_stage_number),
    .out_source_stage (out_source_stage),
    .out_result_stage (out_result_stage),
    .out_step_size    (out_step_size),
    .out_block_offset (out_block_offset),
    .out_target_proc  (out_target_proc),
    .out_last         (out_last),
    .out_error        (out_error)
  );

endmodule

// File: rtl/core/ars_checker.sv
`timescale 1ns / 1ps

module ars_checker
  import ars_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [STG_W-1:0] out_stage_number,
  input logic [STG_W-1:0] out_source_stage,
  input logic [STG_W-1:0] out_result_stage,
  input logic [BLK_W-1:0] out_step_size,
  input logic [IDX_W-1:0] out_target_proc,
  input logic             out_last,
  input logic             out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stage_number) &&
      $stable(out_target_proc) && $stable(out_last) && $stable(out_error))
    else $error("stalled transaction changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_result_stage == '0))
    else $error("error transaction not final");

  a_res_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |->
      out_result_stage == out_stage_number + STG_W'(1))
    else $error("result stage mismatch");

  a_step_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> $onehot(out_step_size) &&
      (out_source_stage <= out_stage_number))
    else $error("bad step or source stage");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while sequencer busy");

endmodule

bind allreduce_stage_schedule ars_checker u_ars_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench
  import ars_pkg::*;
();

  typedef struct packed {
    logic [STG_W-1:0] stage_number;
    logic [STG_W-1:0] source_stage;
    logic [STG_W-1:0] result_stage;
    logic [BLK_W-1:0] step_size;
    logic [BLK_W-1:0] block_offset;
    logic [IDX_W-1:0] target_proc;
    logic             last;
    logic             err;
  } stage_t;

  typedef struct packed {
    logic [IDX_W-1:0] proc_index;
    logic [CNT_W-1:0] proc_count;
    logic             typed;
    stage_t           typed_stage;
  } request_row_t;

  localparam int NUM_DIRECTED   = 22;
  localparam int NUM_RANDOM     = 290;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam stage_t NO_STAGE     = '0;
  localparam stage_t ERROR_STAGE  = '{5'd0, 5'd0, 5'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b1};
  localparam stage_t PAIR_TO_ONE  = '{5'd0, 5'd0, 5'd1, 10'd1, 10'd1, 10'd1, 1'b1, 1'b0};
  localparam stage_t PAIR_TO_ZERO = '{5'd0, 5'd0, 5'd1, 10'd1, 10'd1, 10'd0, 1'b1, 1'b0};

  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{10'd0,    11'd0,    1'b1, ERROR_STAGE},
    '{10'd0,    11'd1,    1'b1, ERROR_STAGE},
    '{10'd1,    11'd1,    1'b1, ERROR_STAGE},
    '{10'd5,    11'd5,    1'b1, ERROR_STAGE},
    '{10'd1023, 11'd1023, 1'b1, ERROR_STAGE},
    '{10'd1023, 11'd1025, 1'b1, ERROR_STAGE},
    '{10'd0,    11'd2047, 1'b1, ERROR_STAGE},
    '{10'd1023, 11'd2046, 1'b1, ERROR_STAGE},
    '{10'd0,    11'd2,    1'b1, PAIR_TO_ONE},
    '{10'd1,    11'd2,    1'b1, PAIR_TO_ZERO},
    '{10'd0,    11'd3,    1'b0, NO_STAGE},
    '{10'd2,    11'd3,    1'b0, NO_STAGE},
    '{10'd3,    11'd4,    1'b0, NO_STAGE},
    '{10'd0,    11'd1024, 1'b0, NO_STAGE},
    '{10'd1023, 11'd1024, 1'b0, NO_STAGE},
    '{10'd0,    11'd1023, 1'b0, NO_STAGE},
    '{10'd1022, 11'd1023, 1'b0, NO_STAGE},
    '{10'd511,  11'd512,  1'b0, NO_STAGE},
    '{10'd100,  11'd513,  1'b0, NO_STAGE},
    '{10'd7,    11'd767,  1'b0, NO_STAGE},
    '{10'd682,  11'd1001, 1'b0, NO_STAGE},
    '{10'd1000, 11'd1021, 1'b0, NO_STAGE}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [IDX_W-1:0] in_proc_index = '0;
  logic [CNT_W-1:0] in_proc_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [STG_W-1:0] out_stage_number;
  logic [STG_W-1:0] out_source_stage;
  logic [STG_W-1:0] out_result_stage;
  logic [BLK_W-1:0] out_step_size;
  logic [BLK_W-1:0] out_block_offset;
  logic [IDX_W-1:0] out_target_proc;
  logic             out_last;
  logic             out_error;

  stage_t pending_stages [$];
  bit     fault_seen = 1'b0;
  int     idle_cycles = 0;
  int     send_calm = 0;
  int     take_calm = 0;

  allreduce_stage_schedule dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_proc_index    (in_proc_index),
    .in_proc_count    (in_proc_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stage_number (out_stage_number),
    .out_source_stage (out_source_stage),
    .out_result_stage (out_result_stage),
    .out_step_size    (out_step_size),
    .out_block_offset (out_block_offset),
    .out_target_proc  (out_target_proc),
    .out_last         (out_last),
    .out_error        (out_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  function automatic void plan_schedule(input logic [IDX_W-1:0] idx,
                                        input logic [CNT_W-1:0] cnt);
    int unsigned steps [$];
    int unsigned srcs [$];
    int unsigned offs [$];
    int unsigned span;
    int unsigned remain;
    int unsigned blk;
    int          doubling;
    stage_t      st;
    if (cnt < CNT_W'(2) || {1'b0, idx} >= cnt || 32'(cnt) > MAX_PROCS) begin
      pending_stages.push_back(ERROR_STAGE);
      return;
    end
    span = 1;
    while (2 * span <= 32'(cnt)) begin
      srcs.push_back(steps.size());
      steps.push_back(span);
      offs.push_back(span);
      span = 2 * span;
    end
    remain = 32'(cnt) - span;
    doubling = steps.size();
    // revisit doubling stages high to low, one per set remainder bit
    for (int s = doubling - 1; s >= 0; s--) begin
      blk = steps[s];
      if (remain >= blk) begin
        srcs.push_back(s);
        steps.push_back(blk);
        offs.push_back(span);
        span += blk;
        remain -= blk;
      end
    end
    for (int k = 0; k < steps.size(); k++) begin
      st.stage_number = STG_W'(k);
      st.source_stage = STG_W'(srcs[k]);
      st.result_stage = STG_W'(k + 1);
      st.step_size    = BLK_W'(steps[k]);
      st.block_offset = BLK_W'(offs[k]);
      st.target_proc  = IDX_W'((32'(idx) + 32'(cnt) - offs[k]) % 32'(cnt));
      st.last         = (k == steps.size() - 1);
      st.err          = 1'b0;
      pending_stages.push_back(st);
    end
  endfunction

  task automatic send_request(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt,
                              input logic typed, input stage_t typed_stage);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_proc_index <= idx;
    in_proc_count <= cnt;
    do @(posedge clk); while (in_stall);
    if (typed) pending_stages.push_back(typed_stage);
    else plan_schedule(idx, cnt);
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fault_seen = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : stage_check_b
    stage_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stages.size() == 0) begin
        $display("%0t: stage transaction with none pending, expected none, actual stage %0d",
                 $time, out_stage_number);
        fault_seen = 1'b1;
      end else begin
        want = pending_stages.pop_front();
        check_field("stage_number", 32'(want.stage_number), 32'(out_stage_number));
        check_field("source_stage", 32'(want.source_stage), 32'(out_source_stage));
        check_field("result_stage", 32'(want.result_stage), 32'(out_result_stage));
        check_field("step_size", 32'(want.step_size), 32'(out_step_size));
        check_field("block_offset", 32'(want.block_offset), 32'(out_block_offset));
        check_field("target_proc", 32'(want.target_proc), 32'(out_target_proc));
        check_field("last", 32'(want.last), 32'(out_last));
        check_field("error", 32'(want.err), 32'(out_error));
      end
    end
  end

  initial begin : result_pacing_b
    int hold;
    forever begin
      hold = draw_wait(take_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : request_feed_b
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    int               mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_request(directed_rows[r].proc_index, directed_rows[r].proc_count,
                   directed_rows[r].typed, directed_rows[r].typed_stage);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        cnt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
      end else begin
        // bias toward short schedules, keep some full-size ones
        cnt = (mode < 6) ? CNT_W'($urandom_range(2, 40)) :
                           CNT_W'($urandom_range(2, MAX_PROCS));
        idx = IDX_W'($urandom_range(0, 32'(cnt) - 1));
      end
      send_request(idx, cnt, 1'b0, NO_STAGE);
    end
    in_valid <= 1'b0;
    while (pending_stages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_seen) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule
